/* rtl/shsr_pkg.sv */
// Shared types, command codes and the half-step pattern table of the stepper driver.
`default_nettype none
package shsr_pkg;

  localparam logic [2:0] CMD_TICK   = 3'd0;
  localparam logic [2:0] CMD_ROTATE = 3'd1;
  localparam logic [2:0] CMD_SET    = 3'd2;
  localparam logic [2:0] CMD_UP     = 3'd3;
  localparam logic [2:0] CMD_DOWN   = 3'd4;

  localparam logic [1:0] ERR_OK         = 2'd0;
  localparam logic [1:0] ERR_ZERO_SPEED = 2'd1;
  localparam logic [1:0] ERR_BUSY       = 2'd2;

  localparam logic [19:0] TICKS_NUMERATOR = 20'd900000;
  // x / 9 == (x * NINTH_RECIP) >> 19 for every x up to 2^16
  localparam logic [15:0] NINTH_RECIP     = 16'd58255;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CNT_MUL,
    ST_CNT_ADD,
    ST_PER_GO,
    ST_PER_WAIT
  } shsr_state_t;

  // controller -> datapath
  typedef struct packed {
    logic accept;
    logic div_start;
    logic cnt_mul;
    logic cnt_latch;
    logic commit;
  } shsr_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic rot_start;
    logic div_done;
  } shsr_sts_t;

  function automatic logic [3:0] half_step(input logic [2:0] idx);
    logic [3:0] pat;
    case (idx)
      3'd0: pat = 4'b1000;
      3'd1: pat = 4'b1010;
      3'd2: pat = 4'b0010;
      3'd3: pat = 4'b0110;
      3'd4: pat = 4'b0100;
      3'd5: pat = 4'b0101;
      3'd6: pat = 4'b0001;
      3'd7: pat = 4'b1001;
      default: pat = 4'b0000;
    endcase
    return pat;
  endfunction

endpackage
`default_nettype wire

/* rtl/shsr_if.sv */
// Valid/ready channel interfaces for command beats and result beats.
`default_nettype none
interface shsr_in_if;
  logic               valid;
  logic               ready;
  logic [2:0]         command;
  logic signed [15:0] angle;
  logic [15:0]        speed;
  logic [2:0]         step_select;

  modport source (output valid, command, angle, speed, step_select, input ready);
  modport sink   (input valid, command, angle, speed, step_select, output ready);
endinterface

interface shsr_out_if;
  logic       valid;
  logic       ready;
  logic [3:0] coils;
  logic [2:0] step_position;
  logic       busy_res;
  logic [1:0] error;

  modport source (output valid, coils, step_position, busy_res, error, input ready);
  modport sink   (input valid, coils, step_position, busy_res, error, output ready);
endinterface
`default_nettype wire

/* rtl/shsr_div.sv */
// Restoring divider, one quotient bit per cycle.
`default_nettype none
module shsr_div #(
  parameter int DW = 20,
  parameter int VW = 16
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          start,
  input  wire logic [DW-1:0] dividend,
  input  wire logic [VW-1:0] divisor,
  output logic               done,
  output logic [DW-1:0]      quotient
);

  localparam int CW = (DW > 1) ? $clog2(DW) : 1;

  logic [VW-1:0] rem_r, rem_nxt;
  logic [DW-1:0] quo_r, quo_nxt;
  logic [VW-1:0] dvs_r, dvs_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          run_r, run_nxt;
  logic          done_r, done_nxt;
  logic [VW:0]   trial;
  logic          fits;

  always_comb begin
    trial = {rem_r, quo_r[DW-1]};
    fits  = (trial >= {1'b0, dvs_r});
  end

  always_comb begin
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dvs_nxt  = dvs_r;
    cnt_nxt  = cnt_r;
    run_nxt  = run_r;
    done_nxt = 1'b0;
    if (start) begin
      rem_nxt = '0;
      quo_nxt = dividend;
      dvs_nxt = divisor;
      cnt_nxt = CW'(DW - 1);
      run_nxt = 1'b1;
    end else if (run_r) begin
      // remainder stays below the divisor, so VW bits hold it
      rem_nxt = fits ? VW'(trial - {1'b0, dvs_r}) : trial[VW-1:0];
      quo_nxt = {quo_r[DW-2:0], fits};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == '0) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dvs_r <= dvs_nxt;
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule
`default_nettype wire

/* rtl/shsr_ctrl.sv */
// Controller: handshakes and sequencing of a rotate start.
`default_nettype none
module shsr_ctrl (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  output logic                 in_ready,
  output logic                 out_valid,
  input  wire logic            out_ready,
  input  wire shsr_pkg::shsr_sts_t sts,
  output shsr_pkg::shsr_cmd_t  cmd
);

  shsr_pkg::shsr_state_t state_r, state_nxt;
  logic out_valid_r, out_valid_nxt;
  logic accept;

  assign in_ready = (state_r == shsr_pkg::ST_IDLE) && (!out_valid_r || out_ready);
  assign accept   = in_valid && in_ready;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      shsr_pkg::ST_IDLE:     if (accept && sts.rot_start) state_nxt = shsr_pkg::ST_CNT_MUL;
      shsr_pkg::ST_CNT_MUL:  state_nxt = shsr_pkg::ST_CNT_ADD;
      shsr_pkg::ST_CNT_ADD:  state_nxt = shsr_pkg::ST_PER_GO;
      shsr_pkg::ST_PER_GO:   state_nxt = shsr_pkg::ST_PER_WAIT;
      shsr_pkg::ST_PER_WAIT: if (sts.div_done) state_nxt = shsr_pkg::ST_IDLE;
      default:               state_nxt = shsr_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd           = '0;
    cmd.accept    = accept;
    cmd.cnt_mul   = (state_r == shsr_pkg::ST_CNT_MUL);
    cmd.cnt_latch = (state_r == shsr_pkg::ST_CNT_ADD);
    cmd.div_start = (state_r == shsr_pkg::ST_PER_GO);
    cmd.commit    = (state_r == shsr_pkg::ST_PER_WAIT) && sts.div_done;
  end

  // result register: a beat that starts no rotation, or a rotate commit, loads it; taking the result empties it
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_ready) out_valid_nxt = 1'b0;
    if ((accept && !sts.rot_start) || cmd.commit) out_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= shsr_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule
`default_nettype wire

/* rtl/shsr_dp.sv */
// Datapath: step state, coil pattern, rotate arithmetic and the result register.
`default_nettype none
module shsr_dp (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic [2:0]         in_command,
  input  wire logic signed [15:0] in_angle,
  input  wire logic [15:0]        in_speed,
  input  wire logic [2:0]         in_step_select,
  input  wire shsr_pkg::shsr_cmd_t cmd,
  output shsr_pkg::shsr_sts_t     sts,
  output logic [3:0]              out_coils,
  output logic [2:0]              out_step_position,
  output logic                    out_busy_res,
  output logic [1:0]              out_error
);

  logic [2:0]  idx_r, idx_nxt;
  logic [3:0]  pat_r, pat_nxt;
  logic [15:0] steps_r, steps_nxt;
  logic [19:0] delay_r, delay_nxt;
  logic [19:0] period_r, period_nxt;
  logic        up_r, up_nxt;
  logic [1:0]  err;

  logic [16:0] mag_r;
  logic [13:0] ninth_r;
  logic [15:0] speed_r;
  logic        neg_r;
  logic [15:0] count_r;

  logic [3:0]  coils_r;
  logic [2:0]  pos_r;
  logic        busy_out_r;
  logic [1:0]  err_r;

  logic        busy;
  logic [16:0] mag;
  logic [32:0] ninth_prod;
  logic [16:0] count_sum;
  logic [19:0] delay_dec;
  logic        div_done;
  logic [19:0] div_quo;

  assign busy  = (steps_r != '0) || (delay_r != '0);
  assign mag   = in_angle[15] ? (17'h10000 - {1'b0, in_angle}) : {1'b0, in_angle};
  assign delay_dec = delay_r - 1'b1;

  // |angle| * 10 / 9 == |angle| + |angle| / 9
  assign ninth_prod = {16'b0, mag_r} * {17'b0, shsr_pkg::NINTH_RECIP};
  assign count_sum  = mag_r + {3'b000, ninth_r};

  assign sts.rot_start = (in_command == shsr_pkg::CMD_ROTATE) && !busy && (in_speed != '0);
  assign sts.div_done  = div_done;

  shsr_div #(.DW(20), .VW(16)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (shsr_pkg::TICKS_NUMERATOR),
    .divisor  (speed_r),
    .done     (div_done),
    .quotient (div_quo)
  );

  always_comb begin
    idx_nxt    = idx_r;
    pat_nxt    = pat_r;
    steps_nxt  = steps_r;
    delay_nxt  = delay_r;
    period_nxt = period_r;
    up_nxt     = up_r;
    err        = shsr_pkg::ERR_OK;
    if (cmd.accept && !sts.rot_start) begin
      if (in_command == shsr_pkg::CMD_TICK) begin
        if (delay_r != '0) begin
          delay_nxt = delay_dec;
          if (delay_dec == '0 && steps_r != '0) begin
            idx_nxt   = up_r ? idx_r + 3'd1 : idx_r - 3'd1;
            pat_nxt   = shsr_pkg::half_step(idx_nxt);
            steps_nxt = steps_r - 16'd1;
            delay_nxt = period_r;
          end
        end
      end else if (in_command <= shsr_pkg::CMD_DOWN && busy) begin
        err = shsr_pkg::ERR_BUSY;
      end else if (in_command == shsr_pkg::CMD_ROTATE) begin
        err = shsr_pkg::ERR_ZERO_SPEED;
      end else if (in_command == shsr_pkg::CMD_SET) begin
        pat_nxt = shsr_pkg::half_step(in_step_select);
      end else if (in_command == shsr_pkg::CMD_UP) begin
        idx_nxt = idx_r + 3'd1;
        pat_nxt = shsr_pkg::half_step(idx_nxt);
      end else if (in_command == shsr_pkg::CMD_DOWN) begin
        idx_nxt = idx_r - 3'd1;
        pat_nxt = shsr_pkg::half_step(idx_nxt);
      end
    end else if (cmd.commit && count_r != '0) begin
      // first step is taken at once, the rest on period expiry
      up_nxt     = !neg_r;
      period_nxt = div_quo;
      idx_nxt    = neg_r ? idx_r - 3'd1 : idx_r + 3'd1;
      pat_nxt    = shsr_pkg::half_step(idx_nxt);
      steps_nxt  = count_r - 16'd1;
      delay_nxt  = div_quo;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r    <= '0;
      pat_r    <= '0;
      steps_r  <= '0;
      delay_r  <= '0;
      period_r <= '0;
      up_r     <= 1'b0;
    end else begin
      idx_r    <= idx_nxt;
      pat_r    <= pat_nxt;
      steps_r  <= steps_nxt;
      delay_r  <= delay_nxt;
      period_r <= period_nxt;
      up_r     <= up_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      mag_r   <= mag;
      speed_r <= in_speed;
      neg_r   <= in_angle[15];
    end
    if (cmd.cnt_mul) ninth_r <= ninth_prod[32:19];
    if (cmd.cnt_latch) count_r <= count_sum[15:0];
    if ((cmd.accept && !sts.rot_start) || cmd.commit) begin
      coils_r    <= pat_nxt;
      pos_r      <= idx_nxt;
      busy_out_r <= (steps_nxt != '0) || (delay_nxt != '0);
      err_r      <= err;
    end
  end

  assign out_coils         = coils_r;
  assign out_step_position = pos_r;
  assign out_busy_res      = busy_out_r;
  assign out_error         = err_r;

endmodule
`default_nettype wire

/* rtl/stepper_half_step_rotator_top.sv */
// Half-step stepper driver top level: controller, datapath and channel wiring.
//
// Usage:
//   in_bus carries command beats: tick (one per microsecond), rotate
//   (angle, speed), set pattern (step_select), step up, step down.
//   out_bus returns one result beat per command beat: coil drive, step
//   position, busy flag and error code.
//   Latency: all commands but an accepted rotate give their result in the
//   cycle after the beat, and a new beat may be taken every cycle.
//   A rotate start forms the step count (multiply by a reciprocal of
//   nine, then add), then runs a division for the tick period from
//   speed; its result arrives once the division is done, and no beat is
//   taken meanwhile.
//   The result register decouples the channels: a new beat is taken while
//   the last result is being taken; while out_bus stalls, in_ready is low.
//   Reset (rst_n low, synchronous): step index and coil pattern go to zero, no
//   rotation is pending and the result register is empty.
`default_nettype none
module stepper_half_step_rotator_top (
  input  wire logic   clk,
  input  wire logic   rst_n,
  shsr_in_if.sink     in_bus,
  shsr_out_if.source  out_bus
);

  shsr_pkg::shsr_cmd_t cmd;
  shsr_pkg::shsr_sts_t sts;

  shsr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_bus.valid),
    .in_ready  (in_bus.ready),
    .out_valid (out_bus.valid),
    .out_ready (out_bus.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  shsr_dp u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_command        (in_bus.command),
    .in_angle          (in_bus.angle),
    .in_speed          (in_bus.speed),
    .in_step_select    (in_bus.step_select),
    .cmd               (cmd),
    .sts               (sts),
    .out_coils         (out_bus.coils),
    .out_step_position (out_bus.step_position),
    .out_busy_res      (out_bus.busy_res),
    .out_error         (out_bus.error)
  );

endmodule
`default_nettype wire
